/* rtl/core/slac_pkg.sv */
// ----------------------------------------------------------------------------
// slac_pkg
// shared types, codes and constants of the lru tag cache model
// ----------------------------------------------------------------------------
package slac_pkg;

  // default sizes of the cache
  localparam int MAX_SET_BITS_DEF = 10;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_WIDTH_DEF   = 32;

  // configuration register widths and limits
  localparam int SET_BITS_W     = 4;
  localparam int WAYS_CFG_W     = 4;
  localparam int WAYS_EFF_W     = 5;
  localparam int BLOCK_BITS_W   = 5;
  localparam int BLOCK_BITS_MAX = 16;
  localparam int SHIFT_W        = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;
  localparam int COUNT_W        = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

  // register reset values
  localparam logic [SET_BITS_W-1:0]   SET_BITS_RST    = 4'd4;
  localparam logic [WAYS_CFG_W-1:0]   WAYS_IN_USE_RST = 4'd1;
  localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RST  = 5'd4;

  // operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  typedef struct packed {
    logic hit;
    logic miss;
    logic eviction;
  } slac_flags_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_REPEAT
  } slac_state_t;

endpackage

/* rtl/core/set_assoc_lru_cache_model.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// tag-only set-associative cache model with lru replacement and hit totals
// ----------------------------------------------------------------------------
// Each set is one row of a single-port-read, single-port-write RAM holding
// valid, tag and lru rank of every way. An access reads the row in the cycle
// the input transfers, compares all ways and writes the updated row back
// when the result register is free; a modify then runs a second access (it
// reuses the written row from a register and is always a hit). The row
// read-then-write means a new access is taken only once the last one is
// written back. An operation code of 3 transfers and produces no result.
// After reset the block runs a clearing pass that writes every row once,
// with in_stall high; configuration writes are taken at any time, cfg_ready
// is always high, and a write to an index beyond the three registers is
// dropped. Results leave through an output register, so the next input can
// transfer while a result waits.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model import slac_pkg::*; #(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // accesses
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [ADDR_WIDTH-1:0] in_address,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic                  out_miss,
  output logic                  out_eviction,
  output logic                  out_last,
  output logic [COUNT_W-1:0]    out_hit_total,
  output logic [COUNT_W-1:0]    out_miss_total,
  output logic [COUNT_W-1:0]    out_eviction_total
);

  localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W = AGE_W;
  localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH = 1 << MAX_SET_BITS;
  localparam int ROW_W = MAX_WAYS * (1 + ADDR_WIDTH + AGE_W);
  localparam int TAG_LO = MAX_WAYS;
  localparam int AGE_LO = MAX_WAYS * (1 + ADDR_WIDTH);

  // configuration registers
  logic [SET_BITS_W-1:0]   set_bits_r;
  logic [WAYS_CFG_W-1:0]   ways_in_use_r;
  logic [BLOCK_BITS_W-1:0] block_bits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= SET_BITS_RST;
      ways_in_use_r <= WAYS_IN_USE_RST;
      block_bits_r  <= BLOCK_BITS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits_r    <= cfg_wdata[SET_BITS_W-1:0];
        CFG_WAYS_IN_USE: ways_in_use_r <= cfg_wdata[WAYS_CFG_W-1:0];
        CFG_BLOCK_BITS:  block_bits_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // out-of-range register values clamp to the supported range
  logic [SHIFT_W-1:0]    sb_eff;
  logic [SHIFT_W-1:0]    bb_eff;
  logic [WAYS_EFF_W-1:0] ways_eff;
  logic [IDX_W-1:0]      set_mask;

  always_comb begin
    sb_eff = (SHIFT_W'(set_bits_r) > SHIFT_W'(MAX_SET_BITS)) ?
             SHIFT_W'(MAX_SET_BITS) : SHIFT_W'(set_bits_r);
    bb_eff = (SHIFT_W'(block_bits_r) > SHIFT_W'(BLOCK_BITS_MAX)) ?
             SHIFT_W'(BLOCK_BITS_MAX) : SHIFT_W'(block_bits_r);
    if (ways_in_use_r == '0) begin
      ways_eff = WAYS_EFF_W'(1);
    end else if (WAYS_EFF_W'(ways_in_use_r) > WAYS_EFF_W'(MAX_WAYS)) begin
      ways_eff = WAYS_EFF_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYS_EFF_W'(ways_in_use_r);
    end
    set_mask = IDX_W'((64'd1 << sb_eff) - 64'd1);
  end

  // set index and tag of the incoming address
  logic [ADDR_WIDTH-1:0] addr_shift;
  logic [IDX_W-1:0]      in_set;
  logic [ADDR_WIDTH-1:0] in_tag;

  assign addr_shift = in_address >> bb_eff;
  assign in_set     = addr_shift[IDX_W-1:0] & set_mask;
  assign in_tag     = in_address >> (bb_eff + sb_eff);

  // control state
  slac_state_t state_r, state_nxt;
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             modify_r;
  logic [IDX_W-1:0] set_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic             in_xfer;
  logic             slot_free;
  logic             clr_done;

  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign clr_done  = clr_cnt_r == IDX_W'(DEPTH - 1);

  // ram and update datapath
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [ROW_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [ROW_W-1:0] ram_rd_data;
  logic [ROW_W-1:0] row_upd_r;
  logic [ROW_W-1:0] row_src;
  logic [ROW_W-1:0] row_new;
  logic             res_load;
  logic             res_last;

  logic [MAX_WAYS-1:0]                 src_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] src_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      src_age;
  logic [MAX_WAYS-1:0]                 upd_valid;
  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] upd_tag;
  logic [MAX_WAYS-1:0][AGE_W-1:0]      upd_age;
  slac_flags_t                         upd_flags;

  slac_row_ram #(
    .ADDR_BITS (MAX_SET_BITS),
    .ROW_W     (ROW_W)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (in_set),
    .rd_data (ram_rd_data)
  );

  // second access of a modify works on the row just written back
  assign row_src   = (state_r == S_REPEAT) ? row_upd_r : ram_rd_data;
  assign src_valid = row_src[MAX_WAYS-1:0];
  assign src_tag   = row_src[TAG_LO +: MAX_WAYS*ADDR_WIDTH];
  assign src_age   = row_src[AGE_LO +: MAX_WAYS*AGE_W];

  slac_set_update #(
    .MAX_WAYS   (MAX_WAYS),
    .ADDR_WIDTH (ADDR_WIDTH),
    .AGE_W      (AGE_W),
    .WAY_W      (WAY_W)
  ) u_set_update (
    .row_valid (src_valid),
    .row_tag   (src_tag),
    .row_age   (src_age),
    .tag       (tag_r),
    .ways_eff  (ways_eff),
    .flags     (upd_flags),
    .new_valid (upd_valid),
    .new_tag   (upd_tag),
    .new_age   (upd_age)
  );

  assign row_new = {upd_age, upd_tag, upd_valid};

  // next state
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        if (clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer && (in_operation != OP_NOP)) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (slot_free) begin
          state_nxt = modify_r ? S_REPEAT : S_IDLE;
        end
      end
      S_REPEAT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall    = 1'b1;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = set_r;
    ram_wr_data = row_new;
    res_load    = 1'b0;
    res_last    = 1'b1;
    case (state_r)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
      end
      S_IDLE: begin
        in_stall  = 1'b0;
        ram_rd_en = in_valid;
      end
      S_LOOK: begin
        ram_wr_en = slot_free;
        res_load  = slot_free;
        res_last  = !modify_r;
      end
      S_REPEAT: begin
        ram_wr_en = slot_free;
        res_load  = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // access context, captured when the input transfers, and the row last written back
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      modify_r <= in_operation == OP_MODIFY;
      set_r    <= in_set;
      tag_r    <= in_tag;
    end
    if (ram_wr_en && (state_r != S_CLEAR)) begin
      row_upd_r <= row_new;
    end
  end

  // running totals, wrap at 2**32
  logic [COUNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [COUNT_W-1:0] miss_cnt_r, miss_cnt_nxt;
  logic [COUNT_W-1:0] evict_cnt_r, evict_cnt_nxt;

  always_comb begin
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    if (res_load) begin
      hit_cnt_nxt   = hit_cnt_r + COUNT_W'(upd_flags.hit);
      miss_cnt_nxt  = miss_cnt_r + COUNT_W'(upd_flags.miss);
      evict_cnt_nxt = evict_cnt_r + COUNT_W'(upd_flags.eviction);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
    end
  end

  // result register
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_hit            <= upd_flags.hit;
      out_miss           <= upd_flags.miss;
      out_eviction       <= upd_flags.eviction;
      out_last           <= res_last;
      out_hit_total      <= hit_cnt_nxt;
      out_miss_total     <= miss_cnt_nxt;
      out_eviction_total <= evict_cnt_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // a modify's second access always finds the line just filled or hit
  a_repeat_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REPEAT && res_load) |-> upd_flags.hit)
    else $error("second access of a modify missed");

  // every result moves exactly one of the hit and miss totals
  a_totals_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (COUNT_W'(hit_cnt_r + miss_cnt_r) ==
                  COUNT_W'($past(hit_cnt_r + miss_cnt_r) + COUNT_W'(1))))
    else $error("hit and miss totals out of step");

  // an eviction is only reported with a miss
  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eviction) |-> out_miss)
    else $error("eviction without miss");

  // the row ram is never written while a new read can be issued
  a_no_wr_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_wr_en)
    else $error("row write while idle");

endmodule

/* rtl/core/slac_row_ram.sv */
// ----------------------------------------------------------------------------
// slac_row_ram
// one row per set, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module slac_row_ram #(
  parameter int ADDR_BITS = 10,
  parameter int ROW_W     = 288
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((ADDR_BITS > 0) ? ADDR_BITS : 1)-1:0] wr_addr,
  input  logic [ROW_W-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((ADDR_BITS > 0) ? ADDR_BITS : 1)-1:0] rd_addr,
  output logic [ROW_W-1:0]                           rd_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [ROW_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/slac_set_update.sv */
// ----------------------------------------------------------------------------
// slac_set_update
// tag compare, victim choice and lru rank update of one set
// ----------------------------------------------------------------------------
module slac_set_update import slac_pkg::*; #(
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32,
  parameter int AGE_W      = 3,
  parameter int WAY_W      = 3
) (
  input  logic [MAX_WAYS-1:0]                 row_valid,
  input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] row_tag,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]      row_age,
  input  logic [ADDR_WIDTH-1:0]               tag,
  input  logic [WAYS_EFF_W-1:0]               ways_eff,
  output slac_flags_t                         flags,
  output logic [MAX_WAYS-1:0]                 new_valid,
  output logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] new_tag,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]      new_age
);

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic                hit;
  logic                have_free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [AGE_W-1:0]    best_age;
  logic [WAY_W-1:0]    target;
  logic [AGE_W-1:0]    hit_age;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = WAYS_EFF_W'(w) < ways_eff;
      match[w]  = in_use[w] && row_valid[w] && (row_tag[w] == tag);
      free[w]   = in_use[w] && !row_valid[w];
    end
  end

  // lowest-numbered matching and lowest-numbered free way
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // oldest way, ties go to the lowest number; way 0 is always in use
  always_comb begin
    victim   = '0;
    best_age = row_age[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (row_age[w] > best_age)) begin
        victim   = WAY_W'(w);
        best_age = row_age[w];
      end
    end
  end

  assign hit       = |match;
  assign have_free = |free;
  assign hit_age   = row_age[hit_way];
  assign target    = hit ? hit_way : (have_free ? free_way : victim);

  assign flags.hit      = hit;
  assign flags.miss     = !hit;
  assign flags.eviction = !hit && !have_free;

  always_comb begin
    new_valid = row_valid;
    new_tag   = row_tag;
    new_age   = row_age;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && row_valid[w] && (WAY_W'(w) != target)) begin
        if ((!hit || (row_age[w] < hit_age)) && (row_age[w] != AGE_MAX)) begin
          new_age[w] = row_age[w] + AGE_W'(1);
        end
      end
    end
    new_age[target]   = '0;
    new_valid[target] = 1'b1;
    if (!hit) begin
      new_tag[target] = tag;
    end
  end

endmodule

/* test/lru_cache_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_checker
// watches the config, access and result channels of the lru tag cache,
// keeps its own copy of the cache state, predicts every result and compares
// ----------------------------------------------------------------------------
module lru_cache_checker import slac_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [ADDR_WIDTH_DEF-1:0] in_address,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_hit,
  input  logic                      out_miss,
  input  logic                      out_eviction,
  input  logic                      out_last,
  input  logic [COUNT_W-1:0]        out_hit_total,
  input  logic [COUNT_W-1:0]        out_miss_total,
  input  logic [COUNT_W-1:0]        out_eviction_total,
  output int                        pending_results,
  output int                        error_count
);

  localparam int NUM_LINES   = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
  localparam int AGE_TOP     = MAX_WAYS_DEF - 1;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    slac_flags_t        flags;
    logic               last;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] miss_total;
    logic [COUNT_W-1:0] eviction_total;
  } cache_result_t;

  // configuration copy
  logic [SET_BITS_W-1:0]   set_bits_q;
  logic [WAYS_CFG_W-1:0]   ways_q;
  logic [BLOCK_BITS_W-1:0] block_bits_q;

  // cache state copy
  bit                        line_valid [NUM_LINES];
  logic [ADDR_WIDTH_DEF-1:0] line_tag   [NUM_LINES];
  logic [2:0]                line_age   [NUM_LINES];
  logic [COUNT_W-1:0]        hits_so_far;
  logic [COUNT_W-1:0]        misses_so_far;
  logic [COUNT_W-1:0]        evictions_so_far;

  cache_result_t expected_results [$];
  int            results_seen;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t checker: %s", $time, msg);
    end
  endtask

  // one cache access; the expected result goes to the back of the queue
  task automatic cache_access(input logic [ADDR_WIDTH_DEF-1:0] addr, input logic is_last);
    int unsigned sb, bb, ways, base, way;
    int best;
    bit found;
    logic [2:0] hit_age;
    logic [ADDR_WIDTH_DEF-1:0] tag;
    cache_result_t res;
    sb   = (set_bits_q > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : set_bits_q;
    bb   = (block_bits_q > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_q;
    ways = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS_DEF) ? MAX_WAYS_DEF : ways_q);
    base = ((addr >> bb) & ((1 << sb) - 1)) * MAX_WAYS_DEF;
    tag  = addr >> (bb + sb);
    found = 1'b0;
    way   = MAX_WAYS_DEF;
    res   = '0;
    for (int unsigned w = 0; w < ways; w++) begin
      if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      hits_so_far++;
      res.flags.hit = 1'b1;
      hit_age = line_age[base+way];
      // only lines more recent than the hit line get older
      for (int unsigned w = 0; w < ways; w++) begin
        if (w != way && line_valid[base+w] && line_age[base+w] < hit_age &&
            line_age[base+w] < AGE_TOP) begin
          line_age[base+w]++;
        end
      end
    end else begin
      misses_so_far++;
      res.flags.miss = 1'b1;
      for (int unsigned w = 0; w < ways; w++) begin
        if (way == MAX_WAYS_DEF && !line_valid[base+w]) way = w;
      end
      if (way == MAX_WAYS_DEF) begin
        // set full: lowest way with the oldest rank goes
        evictions_so_far++;
        res.flags.eviction = 1'b1;
        best = -1;
        way  = 0;
        for (int unsigned w = 0; w < ways; w++) begin
          if (int'(line_age[base+w]) > best) begin
            best = line_age[base+w];
            way  = w;
          end
        end
      end
      for (int unsigned w = 0; w < ways; w++) begin
        if (w != way && line_valid[base+w] && line_age[base+w] < AGE_TOP) begin
          line_age[base+w]++;
        end
      end
      line_valid[base+way] = 1'b1;
      line_tag[base+way]   = tag;
    end
    line_age[base+way] = '0;
    res.last           = is_last;
    res.hit_total      = hits_so_far;
    res.miss_total     = misses_so_far;
    res.eviction_total = evictions_so_far;
    expected_results.push_back(res);
  endtask

  task automatic check_result();
    cache_result_t want;
    results_seen++;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = expected_results.pop_front();
      if (out_hit !== want.flags.hit)
        report_mismatch($sformatf("result %0d hit %b, expected %b",
                                  results_seen, out_hit, want.flags.hit));
      if (out_miss !== want.flags.miss)
        report_mismatch($sformatf("result %0d miss %b, expected %b",
                                  results_seen, out_miss, want.flags.miss));
      if (out_eviction !== want.flags.eviction)
        report_mismatch($sformatf("result %0d eviction %b, expected %b",
                                  results_seen, out_eviction, want.flags.eviction));
      if (out_last !== want.last)
        report_mismatch($sformatf("result %0d last %b, expected %b",
                                  results_seen, out_last, want.last));
      if (out_hit_total !== want.hit_total)
        report_mismatch($sformatf("result %0d hit_total %0d, expected %0d",
                                  results_seen, out_hit_total, want.hit_total));
      if (out_miss_total !== want.miss_total)
        report_mismatch($sformatf("result %0d miss_total %0d, expected %0d",
                                  results_seen, out_miss_total, want.miss_total));
      if (out_eviction_total !== want.eviction_total)
        report_mismatch($sformatf("result %0d eviction_total %0d, expected %0d",
                                  results_seen, out_eviction_total, want.eviction_total));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      set_bits_q       = SET_BITS_RST;
      ways_q           = WAYS_IN_USE_RST;
      block_bits_q     = BLOCK_BITS_RST;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
      foreach (line_age[i]) line_age[i] = '0;
      hits_so_far      = '0;
      misses_so_far    = '0;
      evictions_so_far = '0;
      results_seen     = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_q   = cfg_wdata[SET_BITS_W-1:0];
          CFG_WAYS_IN_USE: ways_q       = cfg_wdata[WAYS_CFG_W-1:0];
          CFG_BLOCK_BITS:  block_bits_q = cfg_wdata[BLOCK_BITS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_LOAD, OP_STORE: cache_access(in_address, 1'b1);
          OP_MODIFY: begin
            cache_access(in_address, 1'b0);
            cache_access(in_address, 1'b1);
          end
          default: ;
        endcase
      end
    end
    pending_results <= expected_results.size();
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// access stimulus and verdict for the lru tag cache; a directed opening,
// then random access streams over a sweep of cache geometries and idle modes
// ----------------------------------------------------------------------------
module testbench;
  import slac_pkg::*;

  // index past the three registers, the block drops writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int IDLE_HEAVY      = 85;
  localparam int IDLE_LIGHT      = 14;
  localparam int SETTLE_CYCLES   = 8;
  localparam int NUM_POINTS      = 7;
  localparam int ITEMS_PER_POINT = 240;
  localparam int POOL_SIZE       = 12;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // raw register values as written, before the block masks and clamps them
  typedef struct packed {
    logic [CFG_DATA_W-1:0] sb;
    logic [CFG_DATA_W-1:0] ways;
    logic [CFG_DATA_W-1:0] bb;
  } config_point_t;

  // geometry sweep: one set and all ways, the largest cache, clamped values,
  // a set register value with bit 4 set, and a direct-mapped cache
  config_point_t geometry_sweep [NUM_POINTS] = '{
    '{5'd0,  5'd8,  5'd0},
    '{5'd10, 5'd8,  5'd4},
    '{5'd15, 5'd0,  5'd31},
    '{5'd2,  5'd4,  5'd16},
    '{5'd20, 5'd15, 5'd3},
    '{5'd1,  5'd2,  5'd5},
    '{5'd3,  5'd1,  5'd0}
  };

  logic clk;
  logic rst_n = 1'b0;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_operation = OP_LOAD;
  logic [ADDR_WIDTH_DEF-1:0] in_address = '0;

  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_hit;
  logic                      out_miss;
  logic                      out_eviction;
  logic                      out_last;
  logic [COUNT_W-1:0]        out_hit_total;
  logic [COUNT_W-1:0]        out_miss_total;
  logic [COUNT_W-1:0]        out_eviction_total;

  int pending_results;
  int error_count;

  // idle percentages of the two sides, changed only between stretches
  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;

  set_assoc_lru_cache_model dut (.*);

  lru_cache_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run including the clear pass
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver stalls at random, one draw per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic set_idle_mode(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin sender_idle_pct = 0;          receiver_stall_pct = 0;          end
      IDLE_SENDER:   begin sender_idle_pct = IDLE_HEAVY; receiver_stall_pct = 0;          end
      IDLE_RECEIVER: begin sender_idle_pct = 0;          receiver_stall_pct = IDLE_HEAVY; end
      default:       begin sender_idle_pct = IDLE_LIGHT; receiver_stall_pct = IDLE_LIGHT; end
    endcase
  endtask

  // one access transfer; valid stays high when the next one follows at once
  task automatic send_access(input logic [1:0] op, input logic [ADDR_WIDTH_DEF-1:0] addr);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_address   <= addr;
    do @(posedge clk); while (in_stall);
    // random sender gap after the transfer
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // sender holds off until every expected result has come back, then lets a
  // trailing no-result operation finish inside the block
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input config_point_t point);
    write_reg(CFG_SET_BITS, point.sb);
    write_reg(CFG_WAYS_IN_USE, point.ways);
    write_reg(CFG_BLOCK_BITS, point.bb);
    write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
  endtask

  initial begin
    logic [1:0]                op;
    logic [ADDR_WIDTH_DEF-1:0] addr;
    logic [ADDR_WIDTH_DEF-1:0] tag_pool [POOL_SIZE];
    int unsigned eff_sb, eff_bb, eff_ways, num_sets, set_idx, roll;
    int done;

    // reset, then the block clears its rows with in_stall high
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed opening at reset geometry: 16 sets, 1 way, 16-byte blocks
    set_idle_mode(IDLE_NONE);
    send_access(OP_LOAD,   32'h0000_0000);   // cold miss
    send_access(OP_LOAD,   32'h0000_000F);   // same block, hit
    send_access(OP_STORE,  32'h0000_0010);   // next set, miss
    send_access(OP_MODIFY, 32'h0000_0100);   // conflict: evict, then hit
    send_access(OP_LOAD,   32'h0000_0000);   // old tag back, evict again
    send_access(OP_NOP,    32'hFFFF_FFFF);   // ignored, no result
    send_access(OP_LOAD,   32'hFFFF_FFFF);   // top set, all-ones tag
    send_access(OP_STORE,  32'hFFFF_FFF0);   // hit on it
    send_access(OP_MODIFY, 32'hFFFF_FFFF);   // modify that hits twice
    send_access(OP_LOAD,   32'h7FFF_FFFF);   // top tag bit differs, evict
    send_access(OP_NOP,    32'h0000_0000);

    for (int k = 0; k < NUM_POINTS; k++) begin
      wait_for_results();
      apply_config(geometry_sweep[k]);

      if (k == 0) begin
        // one set of eight ways: fill it, overflow it, then shuffle ranks
        for (int a = 0; a < 9; a++) send_access(OP_LOAD, a);
        send_access(OP_STORE,  32'd1);       // hit on the oldest line
        send_access(OP_MODIFY, 32'd0);       // evicted earlier, miss then hit
        send_access(OP_LOAD,   32'd2);
      end

      // effective geometry as the block sees it after masking and clamping
      eff_sb   = geometry_sweep[k].sb[SET_BITS_W-1:0];
      eff_sb   = (eff_sb > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : eff_sb;
      eff_ways = geometry_sweep[k].ways[WAYS_CFG_W-1:0];
      eff_ways = (eff_ways == 0) ? 1 : ((eff_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : eff_ways);
      eff_bb   = geometry_sweep[k].bb;
      eff_bb   = (eff_bb > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : eff_bb;
      num_sets = 1 << eff_sb;
      foreach (tag_pool[i]) tag_pool[i] = $urandom;

      for (int half = 0; half < 2; half++) begin
        set_idle_mode(idle_mode_t'((2 * k + half) % 4));
        done = 0;
        while (done < ITEMS_PER_POINT / 2) begin
          roll = $urandom_range(99);
          if (roll < 5) begin
            // unused code, must be swallowed silently
            op   = OP_NOP;
            addr = $urandom;
          end else if (roll < 20) begin
            // noise: any address, mostly cold misses
            op   = 2'($urandom_range(OP_LOAD, OP_MODIFY));
            addr = $urandom;
          end else begin
            // a few hot sets and slightly more tags than ways, so hits,
            // fills and lru evictions all keep happening
            op      = 2'($urandom_range(OP_LOAD, OP_MODIFY));
            set_idx = $urandom_range(0, (num_sets > 4) ? 3 : num_sets - 1);
            addr    = (tag_pool[$urandom_range(0, eff_ways + 1)] << (eff_bb + eff_sb)) |
                      (set_idx << eff_bb) | ($urandom & ((1 << eff_bb) - 1));
          end
          send_access(op, addr);
          if (op != OP_NOP) done++;
        end
      end
    end

    wait_for_results();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/slac_pkg.sv
rtl/core/slac_row_ram.sv
rtl/core/slac_set_update.sv
rtl/core/set_assoc_lru_cache_model.sv
test/lru_cache_checker.sv
test/testbench.sv
